// ===== src/b64e_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, result codes and the base64 alphabet for the stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CAP_W       = 16;
    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h47;  // 'a' minus 26
    localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'h04;  // 52 minus '0'

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic              grp;     // emit one group of four characters
        logic [1:0]        nbytes;  // bytes in the group, 1 to 3
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [BYTE_W-1:0] byte_c;
        logic              ovf;     // overflow result after the group slot
        logic              fin;     // end result after the group
        logic [CNT_W-1:0]  cnt;     // character count for the end result
    } job_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] ch;
        if (v < 6'd26) begin
            ch = CHAR_UPPER + CHAR_W'(v);
        end else if (v < 6'd52) begin
            ch = CHAR_LOWER + CHAR_W'(v);
        end else if (v < 6'd62) begin
            ch = CHAR_W'(v) - CHAR_DIGIT;
        end else if (v == 6'd62) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== src/b64e_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, keeps the pending bytes and count, checks capacity and
// pushes one job per item that causes results.
// ----------------------------------------------------------------------------
module b64e_front #(
    parameter int unsigned COUNT_BITS = b64e_pkg::COUNT_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [b64e_pkg::CAP_W-1:0]  cfg_out_capacity,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [b64e_pkg::BYTE_W-1:0] s_data_byte,
    input  wire logic                        s_carries_byte,
    input  wire logic                        s_end_of_stream,
    input  wire logic                        q_full,
    output logic                             q_push,
    output b64e_pkg::job_t                   q_data
);

    localparam int unsigned CMPW = (COUNT_BITS + 1 > b64e_pkg::CAP_W + 1) ?
                                   COUNT_BITS + 1 : b64e_pkg::CAP_W + 1;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    logic [b64e_pkg::CAP_W-1:0]  cap_reg;
    logic [b64e_pkg::BYTE_W-1:0] first_reg, first_next;
    logic [b64e_pkg::BYTE_W-1:0] second_reg, second_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    logic [CMPW-1:0] next_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            room_ok;
    logic            accept;
    b64e_pkg::job_t  job;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    // at most one group per item, so the check always sees count_reg
    assign next_ext = CMPW'(count_reg) + CMPW'(4);
    assign room_ok  = (next_ext < CMPW'(cap_reg)) && !next_ext[COUNT_BITS];

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        job         = '0;
        cnt_ext     = '0;

        if (!ovf_reg && s_carries_byte) begin
            case (phase_reg)
                PHASE_EMPTY: begin
                    first_next = s_data_byte;
                    phase_next = PHASE_ONE;
                end
                PHASE_ONE: begin
                    second_next = s_data_byte;
                    phase_next  = PHASE_TWO;
                end
                default: begin
                    phase_next = PHASE_EMPTY;
                    if (room_ok) begin
                        job.grp    = 1'b1;
                        job.nbytes = 2'd3;
                        job.byte_a = first_reg;
                        job.byte_b = second_reg;
                        job.byte_c = s_data_byte;
                        count_next = next_ext[COUNT_BITS-1:0];
                    end else begin
                        job.ovf  = 1'b1;
                        ovf_next = 1'b1;
                    end
                end
            endcase
        end

        if (s_end_of_stream) begin
            if (!ovf_next) begin
                if (phase_next != PHASE_EMPTY) begin
                    if (room_ok) begin
                        job.grp    = 1'b1;
                        job.nbytes = phase_next;
                        job.byte_a = first_next;
                        job.byte_b = (phase_next == PHASE_TWO) ? second_next : '0;
                        job.byte_c = '0;
                        count_next = next_ext[COUNT_BITS-1:0];
                    end else begin
                        job.ovf  = 1'b1;
                        ovf_next = 1'b1;
                    end
                end
                if (!ovf_next) begin
                    cnt_ext = CMPW'(count_next);
                    job.fin = 1'b1;
                    job.cnt = cnt_ext[b64e_pkg::CNT_W-1:0];
                end
            end
            first_next  = '0;
            second_next = '0;
            phase_next  = PHASE_EMPTY;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    assign q_push = accept && (job.grp || job.ovf || job.fin);
    assign q_data = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= b64e_pkg::CAP_RESET;
            first_reg  <= '0;
            second_reg <= '0;
            phase_reg  <= PHASE_EMPTY;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_out_capacity;
            end
            if (accept) begin
                first_reg  <= first_next;
                second_reg <= second_next;
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/b64e_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire b64e_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output b64e_pkg::job_t      pop_data,
    output logic                empty
);

    localparam int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    b64e_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full job queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from an empty job queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("job queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("job queue count missed a push");
`endif

endmodule
`default_nettype wire

// ===== src/b64e_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Takes jobs from the queue and sends their results one per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    input  wire b64e_pkg::job_t              q_data,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [b64e_pkg::KIND_W-1:0]      m_kind,
    output logic [b64e_pkg::CHAR_W-1:0]      m_out_char,
    output logic [b64e_pkg::CNT_W-1:0]       m_char_count,
    output logic                             m_last_of_run
);

    b64e_pkg::job_t cur_reg;
    logic           cur_valid_reg;
    logic [2:0]     idx_reg;

    logic                          m_valid_reg;
    logic [b64e_pkg::KIND_W-1:0]   kind_reg;
    logic [b64e_pkg::CHAR_W-1:0]   char_reg;
    logic [b64e_pkg::CNT_W-1:0]    cnt_reg;
    logic                          last_reg;

    logic [2:0]                    last_idx;
    logic                          is_char;
    logic [5:0]                    sextet;
    logic [b64e_pkg::CHAR_W-1:0]   ch;
    logic                          out_free;
    logic                          adv;
    logic                          at_last;

    always_comb begin
        if (cur_reg.grp) begin
            last_idx = (cur_reg.ovf || cur_reg.fin) ? 3'd4 : 3'd3;
        end else begin
            last_idx = 3'd0;
        end
    end

    assign is_char = cur_reg.grp && (idx_reg < 3'd4);
    assign at_last = (idx_reg == last_idx);

    always_comb begin
        case (idx_reg[1:0])
            2'd0:    sextet = cur_reg.byte_a[7:2];
            2'd1:    sextet = {cur_reg.byte_a[1:0], cur_reg.byte_b[7:4]};
            2'd2:    sextet = {cur_reg.byte_b[3:0], cur_reg.byte_c[7:6]};
            default: sextet = cur_reg.byte_c[5:0];
        endcase
        ch = b64e_pkg::b64_char(sextet);
        // padding for short groups at the end of a stream
        if (idx_reg[1:0] == 2'd2 && cur_reg.nbytes < 2'd2) begin
            ch = b64e_pkg::CHAR_PAD;
        end
        if (idx_reg[1:0] == 2'd3 && cur_reg.nbytes < 2'd3) begin
            ch = b64e_pkg::CHAR_PAD;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = cur_valid_reg && out_free;
    assign q_pop    = !q_empty && (!cur_valid_reg || (adv && at_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (adv && at_last) begin
                cur_valid_reg <= 1'b0;
            end else if (adv) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (is_char) begin
                kind_reg <= b64e_pkg::KIND_CHAR;
                char_reg <= ch;
                cnt_reg  <= '0;
            end else if (cur_reg.ovf) begin
                kind_reg <= b64e_pkg::KIND_OVERFLOW;
                char_reg <= '0;
                cnt_reg  <= '0;
            end else begin
                kind_reg <= b64e_pkg::KIND_END;
                char_reg <= '0;
                cnt_reg  <= cur_reg.cnt;
            end
            last_reg <= at_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_out_char    = char_reg;
    assign m_char_count  = cnt_reg;
    assign m_last_of_run = last_reg;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (idx_reg <= last_idx))
        else $error("result index past the end of its job");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.grp || cur_reg.ovf || cur_reg.fin))
        else $error("job with no results");

    a_tail_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> !(cur_reg.ovf && cur_reg.fin))
        else $error("job carries both overflow and end");
`endif

endmodule
`default_nettype wire

// ===== src/base64_stream_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder with output capacity check and end-of-stream count.
//
// Input channel s_*: one byte per transfer, s_carries_byte marks a real byte,
// s_end_of_stream closes the stream (padding group, then an end result with
// the character count). Output channel m_*: one result per transfer, kind
// character, overflow or end; m_last_of_run flags the last result of an item.
// cfg_*: writes out_capacity; cfg_ready is always high.
// An accepted input writes a job into the queue; the back end loads it into
// its job register, then into the output register that drives m_*. The back
// end sends one result per cycle while m_ready is high; items that cause no
// result push no job. The front end takes an item every cycle while the
// four-entry job queue has room; when the receiver stalls, the output register
// holds and the queue fills, after which s_ready drops.
// Reset clears the stream state, the queue and the output stage, and sets
// out_capacity to 65535.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
    parameter int unsigned COUNT_BITS = b64e_pkg::COUNT_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [b64e_pkg::CAP_W-1:0]  cfg_out_capacity,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [b64e_pkg::BYTE_W-1:0] s_data_byte,
    input  wire logic                        s_carries_byte,
    input  wire logic                        s_end_of_stream,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [b64e_pkg::KIND_W-1:0]      m_kind,
    output logic [b64e_pkg::CHAR_W-1:0]      m_out_char,
    output logic [b64e_pkg::CNT_W-1:0]       m_char_count,
    output logic                             m_last_of_run
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    b64e_pkg::job_t q_in;
    b64e_pkg::job_t q_out;

    b64e_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_out_capacity (cfg_out_capacity),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_carries_byte   (s_carries_byte),
        .s_end_of_stream  (s_end_of_stream),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    b64e_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_char    (m_out_char),
        .m_char_count  (m_char_count),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== bench/base64_stream_encoder_top_test.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top_test
// Self-checking bench for the streaming base64 encoder. Byte streams go in
// over s_*, each result leaving m_* is checked in order against a predicted
// character stream, including padding, end counts and capacity overflow.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  ch;
    logic [15:0] cnt;
    logic        last;
} enc_result_t;

class b64_scoreboard;
    bit [15:0]   capacity;
    bit [7:0]    held_a;
    bit [7:0]    held_b;
    bit [1:0]    pending_bytes;
    bit [15:0]   char_total;
    bit          dropping;
    string       alphabet;
    enc_result_t run_q[$];
    enc_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
        alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        capacity   = b64e_pkg::CAP_RESET;
        mismatches = 0;
        checked    = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        held_a        = '0;
        held_b        = '0;
        pending_bytes = '0;
        char_total    = '0;
        dropping      = 1'b0;
    endfunction

    function void set_capacity(input bit [15:0] v);
        capacity = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [6:0] enc_char(input logic [5:0] idx);
        byte c;
        c = alphabet[idx];
        return c[6:0];
    endfunction

    function void push_result(input logic [1:0] kind, input logic [6:0] ch,
                              input logic [15:0] cnt);
        enc_result_t r;
        r.kind = kind;
        r.ch   = ch;
        r.cnt  = cnt;
        r.last = 1'b0;
        run_q.push_back(r);
    endfunction

    // capacity check ahead of each group of four
    function bit room_for_group();
        int unsigned next_total;
        next_total = char_total + 4;
        if (next_total >= capacity || next_total > 16'hFFFF) begin
            push_result(b64e_pkg::KIND_OVERFLOW, '0, '0);
            dropping = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void emit_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input int nbytes);
        push_result(b64e_pkg::KIND_CHAR, enc_char(a[7:2]), '0);
        push_result(b64e_pkg::KIND_CHAR, enc_char({a[1:0], b[7:4]}), '0);
        push_result(b64e_pkg::KIND_CHAR,
                    (nbytes >= 2) ? enc_char({b[3:0], c[7:6]}) : b64e_pkg::CHAR_PAD, '0);
        push_result(b64e_pkg::KIND_CHAR,
                    (nbytes == 3) ? enc_char(c[5:0]) : b64e_pkg::CHAR_PAD, '0);
        char_total = char_total + 16'd4;
    endfunction

    function void note_input(input logic [7:0] d, input logic carries, input logic eos);
        run_q.delete();
        if (!dropping && carries) begin
            case (pending_bytes)
                2'd0: begin
                    held_a        = d;
                    pending_bytes = 2'd1;
                end
                2'd1: begin
                    held_b        = d;
                    pending_bytes = 2'd2;
                end
                default: begin
                    pending_bytes = 2'd0;
                    if (room_for_group())
                        emit_group(held_a, held_b, d, 3);
                end
            endcase
        end
        if (eos) begin
            if (!dropping) begin
                if (pending_bytes != 2'd0) begin
                    if (room_for_group())
                        emit_group(held_a, (pending_bytes == 2'd2) ? held_b : 8'h00, 8'h00,
                                   int'(pending_bytes));
                end
                if (!dropping)
                    push_result(b64e_pkg::KIND_END, '0, char_total);
            end
            clear_stream();
        end
        if (run_q.size() > 0)
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            expected_q.push_back(run_q[i]);
    endfunction

    function void check_result(input logic [1:0] kind, input logic [6:0] ch,
                               input logic [15:0] cnt, input logic last);
        enc_result_t got;
        enc_result_t want;
        got.kind = kind;
        got.ch   = ch;
        got.cnt  = cnt;
        got.last = last;
        checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: nothing expected, got kind %0d char %0d count %0d last %0d",
                         checked, kind, ch, cnt, last);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected kind %0d char %0d count %0d last %0d,",
                         checked, want.kind, want.ch, want.cnt, want.last,
                         " got %0d %0d %0d %0d", kind, ch, cnt, last);
        end
    endfunction
endclass

module base64_stream_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned PHASE_ITEMS   = 30;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [b64e_pkg::CAP_W-1:0]         cfg_out_capacity;
    logic                               s_valid;
    logic                               s_ready;
    logic [b64e_pkg::BYTE_W-1:0]        s_data_byte;
    logic                               s_carries_byte;
    logic                               s_end_of_stream;
    logic                               m_valid;
    logic                               m_ready;
    logic [b64e_pkg::KIND_W-1:0]        m_kind;
    logic [b64e_pkg::CHAR_W-1:0]        m_out_char;
    logic [b64e_pkg::CNT_W-1:0]         m_char_count;
    logic                               m_last_of_run;

    b64_scoreboard enc_sb;
    bit            quiet_in;
    bit            quiet_out;
    bit            hold_req;
    int unsigned   cycles;
    int unsigned   items_sent;

    base64_stream_encoder_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_out_capacity (cfg_out_capacity),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_carries_byte   (s_carries_byte),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_out_char       (m_out_char),
        .m_char_count     (m_char_count),
        .m_last_of_run    (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** base64_stream_encoder_top: FAILED **");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin : result_side
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            stall = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            enc_sb.check_result(m_kind, m_out_char, m_char_count, m_last_of_run);
            @(negedge aclk);
        end
    end

    // called at a falling edge; leaves s_valid high so a zero gap keeps it up
    task automatic send_item(input logic [7:0] d, input logic carries, input logic eos);
        int unsigned gap;
        gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data_byte     = d;
        s_carries_byte  = carries;
        s_end_of_stream = eos;
        s_valid         = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        enc_sb.note_input(d, carries, eos);
        if (carries || eos)
            items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (enc_sb.pending() != 0) @(negedge aclk);
        // items with no result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait_idle();
        cfg_out_capacity = v;
        cfg_valid        = 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        enc_sb.set_capacity(v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random bytes with an occasional empty item mixed in
    task automatic send_stream(input int unsigned nbytes, input bit separate_end);
        for (int unsigned i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !separate_end && (i == nbytes - 1));
        end
        if (separate_end || nbytes == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        logic [15:0] caps[5];
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_out_capacity = '0;
        s_valid          = 1'b0;
        s_data_byte      = '0;
        s_carries_byte   = 1'b0;
        s_end_of_stream  = 1'b0;
        quiet_in         = 1'b0;
        quiet_out        = 1'b0;
        hold_req         = 1'b0;
        items_sent       = 0;
        enc_sb           = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // full group closed by the last byte
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        // one byte, double pad
        send_item(8'hFF, 1'b1, 1'b1);
        // two bytes, then an end with no byte
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
        // item that does nothing, then an empty stream
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // top of the alphabet
        send_item(8'hFB, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hBF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);

        // capacity lowered mid-stream, rest of the stream dropped
        write_capacity(16'd20);
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h56, 1'b1, 1'b0);
        write_capacity(16'd8);
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'h9A, 1'b1, 1'b0);
        send_item(8'hBC, 1'b1, 1'b0);
        send_item(8'hDE, 1'b1, 1'b0);
        send_item(8'hF0, 1'b1, 1'b1);
        // zero capacity, overflow on the marked item itself
        write_capacity(16'd0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h02, 1'b1, 1'b0);
        send_item(8'h03, 1'b1, 1'b1);
        // padded group hits the limit, then just fits
        write_capacity(16'd4);
        send_item(8'h7E, 1'b1, 1'b1);
        write_capacity(16'd5);
        send_item(8'h81, 1'b1, 1'b1);

        caps[0] = 16'hFFFF;
        caps[1] = 16'($urandom_range(0, 40));
        caps[2] = 16'd0;
        caps[3] = 16'($urandom);
        caps[4] = 16'd13;
        for (int p = 0; p < 5; p++) begin
            write_capacity(caps[p]);
            quiet_in   = ($urandom_range(0, 3) == 0);
            quiet_out  = ($urandom_range(0, 3) == 0);
            items_sent = 0;
            if (p == 0) begin
                // receiver holds off while bytes keep coming
                hold_req = 1'b1;
                quiet_in = 1'b1;
                send_stream(30, 1'b0);
                quiet_in = 1'b0;
            end
            while (items_sent < PHASE_ITEMS)
                send_stream($urandom_range(0, 10), 1'($urandom_range(0, 1)));
        end

        wait_idle();
        if (enc_sb.mismatches == 0 && enc_sb.pending() == 0) begin
            $display("** base64_stream_encoder_top: PASSED **");
        end else begin
            $display("** base64_stream_encoder_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder_top.sv
bench/base64_stream_encoder_top_test.sv
